FILE: rtl/core/mfm_pkg.sv
`timescale 1ns / 1ps
// mfm_pkg: shared types, constants and helper functions of the mfm track formatter.
// No dependencies; used by mfm_front, mfm_back and mfm_track_formatter.
package mfm_pkg;

  localparam int unsigned CURSOR_BITS = 25;
  localparam int unsigned TrackBits   = 24;
  localparam int unsigned GapBits     = 16;
  localparam int unsigned AdvBits     = GapBits + 1;
  localparam int unsigned CmpBits     = (CURSOR_BITS > TrackBits) ? CURSOR_BITS : TrackBits;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrBits    = $clog2(QueueDepth);
  localparam int unsigned QCntBits    = $clog2(QueueDepth + 1);
  localparam int unsigned InDataBits  = 24;
  localparam int unsigned OutDataBits = 96;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_HEADER_MARKER = 3'd0,
    CFG_DATA_MARKER   = 3'd1,
    CFG_GAP1_PAIRS    = 3'd2,
    CFG_GAP3_PAIRS    = 3'd3,
    CFG_GAP4_PAIRS    = 3'd4,
    CFG_TRACK_CELLS   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_START,
    PH_HMARK,
    PH_HDR,
    PH_GAP3,
    PH_DMARK,
    PH_ODD
  } phase_e;

  // one classified input word as it waits in the queue
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] b0;
    logic [7:0] sec;
    logic [7:0] chk;
    logic [7:0] dbyte;
    logic       last;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] cells;
    logic [6:0]  count;
    logic [23:0] pairs;
    logic        ovr;
    logic        last;
  } result_t;

  typedef struct packed {
    logic          we;
    cfg_idx_e      idx;
    logic [63:0]   data;
  } cfg_wr_t;

  // mfm: each data bit goes out as clock then data, clock = nor of neighbor data bits
  function automatic logic [15:0] mfm16(logic prev, logic [7:0] byte_in);
    logic [15:0] r;
    logic [8:0]  d;
    r = '0;
    d = {prev, byte_in};
    for (int i = 0; i < 8; i++) begin
      r[2*i+1] = ~(d[i+1] | d[i]);
      r[2*i]   = d[i];
    end
    return r;
  endfunction

  function automatic logic [CURSOR_BITS-1:0] cursor_add(logic [CURSOR_BITS-1:0] cur,
                                                        logic [AdvBits-1:0] n);
    logic [CURSOR_BITS:0] s;
    s = {1'b0, cur} + (CURSOR_BITS + 1)'(n);
    return s[CURSOR_BITS] ? '1 : s[CURSOR_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/mfm_front.sv
`timescale 1ns / 1ps
// mfm_front: accepts input words, works out the header bytes and queues jobs.
// Depends on mfm_pkg.
module mfm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mfm_pkg::cmd_e             in_cmd_i,
  input  logic [6:0]                in_track_i,
  input  logic                      in_side_i,
  input  logic [7:0]                in_sector_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_last_i,
  output logic                      job_valid_o,
  output mfm_pkg::job_t             job_o,
  input  logic                      job_pop_i
);
  import mfm_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntBits-1:0]  cnt_q, cnt_d;
  job_t                 job_new;
  logic                 push, pop;

  always_comb begin
    job_new.cmd   = in_cmd_i;
    job_new.b0    = {in_track_i, in_side_i};
    job_new.sec   = in_sector_i;
    // header check byte: inverted sum of the first three header bytes
    job_new.chk   = ~(job_new.b0 + 8'd1 + in_sector_i);
    job_new.dbyte = in_byte_i;
    job_new.last  = in_last_i;
  end

  assign in_ready_o  = (cnt_q != QCntBits'(QueueDepth));
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = job_pop_i & job_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

FILE: rtl/core/mfm_back.sv
`timescale 1ns / 1ps
// mfm_back: configuration registers, track state and the result sequencer.
// Depends on mfm_pkg; takes jobs from mfm_front.
module mfm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfm_pkg::cfg_wr_t    cfg_i,
  input  logic                job_valid_i,
  input  mfm_pkg::job_t       job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfm_pkg::result_t    out_o
);
  import mfm_pkg::*;

  logic [63:0]            hmark_q, dmark_q;
  logic [GapBits-1:0]     gap1_q, gap3_q, gap4_q;
  logic [TrackBits-1:0]   track_q;

  logic [CURSOR_BITS-1:0] cursor_q, cursor_d;
  logic                   prev_q, prev_d;
  logic                   first_q, first_d;
  logic [7:0]             sum_q, sum_d;
  phase_e                 phase_q, phase_d;

  result_t                res, out_q;
  logic                   out_valid_q;
  logic                   adv;

  logic [CmpBits-1:0]     cur_ext, trk_ext;
  logic                   ovr;
  logic [TrackBits-1:0]   rest;
  logic [7:0]             dsum;
  logic [7:0]             dsum_n;
  logic [15:0]            enc0, enc1;
  logic [63:0]            hdr_cells;

  assign adv       = job_valid_i & (~out_valid_q | out_ready_i);
  assign job_pop_o = adv & res.last;

  // end of track: compare and remainder
  assign cur_ext = CmpBits'(cursor_q);
  assign trk_ext = CmpBits'(track_q);
  assign ovr     = cur_ext > trk_ext;
  assign rest    = ovr ? '0 : TrackBits'(trk_ext - cur_ext);

  // data byte and running checksum
  assign dsum   = sum_q + job_i.dbyte;
  assign dsum_n = ~dsum;
  assign enc0   = mfm16(prev_q, job_i.dbyte);
  assign enc1   = mfm16(job_i.dbyte[0], dsum_n);

  // header field, previous bit comes from the header marker
  assign hdr_cells = {mfm16(prev_q, job_i.b0),
                      mfm16(job_i.b0[0], 8'd1),
                      mfm16(1'b1, job_i.sec),
                      mfm16(job_i.sec[0], job_i.chk)};

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (adv) begin
      unique case (phase_q)
        PH_START: begin
          unique case (job_i.cmd)
            CMD_HEADER: phase_d = first_q ? PH_HDR : PH_HMARK;
            CMD_END:    phase_d = rest[0] ? PH_ODD : PH_START;
            default:    phase_d = PH_START;
          endcase
        end
        PH_HMARK: phase_d = PH_HDR;
        PH_HDR:   phase_d = PH_GAP3;
        PH_GAP3:  phase_d = PH_DMARK;
        PH_DMARK: phase_d = PH_START;
        PH_ODD:   phase_d = PH_START;
        default:  phase_d = PH_START;
      endcase
    end
  end

  // result and state update for the current phase
  always_comb begin
    res      = '0;
    cursor_d = cursor_q;
    prev_d   = prev_q;
    first_d  = first_q;
    sum_d    = sum_q;
    unique case (phase_q)
      PH_START: begin
        unique case (job_i.cmd)
          CMD_START: begin
            res.kind  = 1'b1;
            res.pairs = 24'(gap1_q);
            res.last  = 1'b1;
            cursor_d  = cursor_add('0, {gap1_q, 1'b0});
            prev_d    = 1'b0;
            first_d   = 1'b1;
            sum_d     = '0;
          end
          CMD_HEADER: begin
            first_d = 1'b0;
            sum_d   = '0;
            if (first_q) begin
              res.cells = hmark_q;
              res.count = 7'd64;
              cursor_d  = cursor_add(cursor_q, AdvBits'(64));
              prev_d    = hmark_q[0];
            end else begin
              res.kind  = 1'b1;
              res.pairs = 24'(gap4_q);
              cursor_d  = cursor_add(cursor_q, {gap4_q, 1'b0});
              if (gap4_q != '0) begin
                prev_d = 1'b0;
              end
            end
          end
          CMD_DATA: begin
            res.last = 1'b1;
            if (job_i.last) begin
              res.cells = {32'd0, enc0, enc1};
              res.count = 7'd32;
              cursor_d  = cursor_add(cursor_q, AdvBits'(32));
              prev_d    = dsum_n[0];
              sum_d     = '0;
            end else begin
              res.cells = {48'd0, enc0};
              res.count = 7'd16;
              cursor_d  = cursor_add(cursor_q, AdvBits'(16));
              prev_d    = job_i.dbyte[0];
              sum_d     = dsum;
            end
          end
          CMD_END: begin
            res.kind  = 1'b1;
            res.pairs = {1'b0, rest[TrackBits-1:1]};
            res.ovr   = ovr;
            res.last  = ~rest[0];
            cursor_d  = ovr ? cursor_q : CURSOR_BITS'(trk_ext);
            prev_d    = 1'b0;
          end
          default: ;
        endcase
      end
      PH_HMARK: begin
        res.cells = hmark_q;
        res.count = 7'd64;
        cursor_d  = cursor_add(cursor_q, AdvBits'(64));
        prev_d    = hmark_q[0];
      end
      PH_HDR: begin
        res.cells = hdr_cells;
        res.count = 7'd64;
        cursor_d  = cursor_add(cursor_q, AdvBits'(64));
        prev_d    = job_i.chk[0];
      end
      PH_GAP3: begin
        res.kind  = 1'b1;
        res.pairs = 24'(gap3_q);
        cursor_d  = cursor_add(cursor_q, {gap3_q, 1'b0});
        if (gap3_q != '0) begin
          prev_d = 1'b0;
        end
      end
      PH_DMARK: begin
        res.cells = dmark_q;
        res.count = 7'd64;
        res.last  = 1'b1;
        cursor_d  = cursor_add(cursor_q, AdvBits'(64));
        prev_d    = dmark_q[0];
      end
      PH_ODD: begin
        // odd leftover cell at the end of the track
        res.cells = 64'd1;
        res.count = 7'd1;
        res.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmark_q <= '0;
      dmark_q <= '0;
      gap1_q  <= '0;
      gap3_q  <= '0;
      gap4_q  <= '0;
      track_q <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_HEADER_MARKER: hmark_q <= cfg_i.data;
        CFG_DATA_MARKER:   dmark_q <= cfg_i.data;
        CFG_GAP1_PAIRS:    gap1_q  <= cfg_i.data[GapBits-1:0];
        CFG_GAP3_PAIRS:    gap3_q  <= cfg_i.data[GapBits-1:0];
        CFG_GAP4_PAIRS:    gap4_q  <= cfg_i.data[GapBits-1:0];
        CFG_TRACK_CELLS:   track_q <= cfg_i.data[TrackBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      prev_q      <= 1'b0;
      first_q     <= 1'b1;
      sum_q       <= '0;
      phase_q     <= PH_START;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (adv) begin
        cursor_q    <= cursor_d;
        prev_q      <= prev_d;
        first_q     <= first_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/core/mfm_track_formatter.sv
`timescale 1ns / 1ps
// mfm_track_formatter: top level of the mfm floppy track builder.
// Depends on mfm_pkg, mfm_front and mfm_back.
//
// Usage: write the six track registers on the cfg port while the block is idle
// (index 0 header marker, 1 data marker, 2..4 gap pair counts, 5 track length).
// Send commands on the s_axis channel: start track, sector header, data byte
// (tlast on the final payload byte), end track. Each word yields one to five
// result words on m_axis: literal raw cells or a run of filler pairs, with
// tlast on the last result of a command.
// A word accepted on an empty block is written to the job queue, and the back end
// builds its first result into the output register. With the receiver ready,
// results flow at one word per cycle; data bytes stream at one per cycle, a header
// gives four or five result words and an odd end of track two. The single result
// register of the back end sets the rate; it takes jobs from a two-entry queue.
// Reset empties the queue, drops the output valid and clears the registers and the
// track state. When the receiver stalls, the pending result holds, the back end
// pauses and the front keeps accepting until the job queue is full.
module mfm_track_formatter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mfm_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [63:0]                       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // track_number[6:0], side[7], sector_number[15:8], data_byte[23:16]
  input  logic [mfm_pkg::InDataBits-1:0]    s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cells[63:0], cell_count[70:64], run_pairs[94:71], overrun[95]
  output logic [mfm_pkg::OutDataBits-1:0]   m_axis_tdata,
  // kind[0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import mfm_pkg::*;

  cfg_wr_t  cfg;
  job_t     job;
  logic     job_valid, job_pop;
  result_t  res;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_e'(cfg_index_i);
  assign cfg.data = cfg_data_i;

  mfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd_e'(s_axis_tuser)),
    .in_track_i  (s_axis_tdata[6:0]),
    .in_side_i   (s_axis_tdata[7]),
    .in_sector_i (s_axis_tdata[15:8]),
    .in_byte_i   (s_axis_tdata[23:16]),
    .in_last_i   (s_axis_tlast),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  mfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {res.ovr, res.pairs, res.count, res.cells};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

FILE: sim/tb_mfm_track_formatter.sv
`timescale 1ns / 1ps
// tb_mfm_track_formatter: self-checking testbench of the mfm track formatter.
// Needs mfm_pkg and the formatter rtl; an in-bench track model predicts every result word.
module tb_mfm_track_formatter;
  import mfm_pkg::*;

  localparam longint unsigned CursorMax = (64'd1 << CURSOR_BITS) - 64'd1;
  localparam logic [CfgIdxBits-1:0] SpareIndex = 3'd7;  // decodes to no register
  localparam int DrainLimit = 5000;
  localparam int MaxReports = 10;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] trk;
    logic       side;
    logic [7:0] sec;
    logic [7:0] dbyte;
    logic       last;
  } track_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] cells;
    logic [6:0]  count;
    logic [23:0] pairs;
    logic        ovr;
    logic        last;
  } cell_word_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [63:0]            cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  mfm_track_formatter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // track model: register copies and formatter state
  logic [63:0]            hdr_mark;
  logic [63:0]            data_mark;
  logic [15:0]            gap1_len;
  logic [15:0]            gap3_len;
  logic [15:0]            gap4_len;
  logic [23:0]            track_len;
  logic [CURSOR_BITS-1:0] cursor_q;
  logic                   last_data_bit;
  logic                   first_sector_q;
  logic [7:0]             pay_sum;

  cell_word_t burst[$];
  cell_word_t cells_due[$];
  cell_word_t seen_word;
  cell_word_t due_word;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold = 0;
  int err_count = 0;
  int items_sent = 0;
  int words_checked = 0;
  int overrun_words = 0;
  int cmd_seen[4];

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model
  function automatic logic [15:0] encode_byte(logic [7:0] b);
    logic [15:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[13:0], ~(last_data_bit | b[i]), b[i]};
      last_data_bit = b[i];
    end
    return r;
  endfunction

  function automatic void advance_cursor(longint unsigned n);
    longint unsigned s;
    s = longint'(cursor_q) + n;
    if (s > CursorMax) cursor_q = '1;
    else cursor_q = s[CURSOR_BITS-1:0];
  endfunction

  function automatic void add_word(logic kind, logic [63:0] cells, logic [6:0] count,
                                   logic [23:0] pairs, logic ovr);
    burst.push_back({kind, cells, count, pairs, ovr, 1'b0});
  endfunction

  function automatic void add_filler(logic [15:0] pairs);
    advance_cursor(64'(pairs) * 2);
    if (pairs != 0) last_data_bit = 1'b0;
    add_word(1'b1, 64'd0, 7'd0, 24'(pairs), 1'b0);
  endfunction

  function automatic void add_marker(logic [63:0] cells);
    advance_cursor(64);
    last_data_bit = cells[0];
    add_word(1'b0, cells, 7'd64, 24'd0, 1'b0);
  endfunction

  function automatic void format_command(track_cmd_t c);
    logic [7:0]             b0;
    logic [7:0]             chk;
    logic [15:0]            m0, m1, m2, m3;
    logic [CURSOR_BITS-1:0] rest;
    logic                   ovr;
    cell_word_t             word;
    burst.delete();
    case (c.cmd)
      CMD_START: begin
        cursor_q = '0;
        last_data_bit = 1'b0;
        first_sector_q = 1'b1;
        pay_sum = '0;
        add_filler(gap1_len);
      end
      CMD_HEADER: begin
        b0 = {c.trk, c.side};
        chk = ~(b0 + 8'd1 + c.sec);
        if (!first_sector_q) add_filler(gap4_len);
        first_sector_q = 1'b0;
        pay_sum = '0;
        add_marker(hdr_mark);
        // called one by one: the clock cell chains across bytes
        m0 = encode_byte(b0);
        m1 = encode_byte(8'd1);
        m2 = encode_byte(c.sec);
        m3 = encode_byte(chk);
        advance_cursor(64);
        add_word(1'b0, {m0, m1, m2, m3}, 7'd64, 24'd0, 1'b0);
        add_filler(gap3_len);
        add_marker(data_mark);
      end
      CMD_DATA: begin
        m0 = encode_byte(c.dbyte);
        pay_sum = pay_sum + c.dbyte;
        if (c.last) begin
          m1 = encode_byte(~pay_sum);
          pay_sum = '0;
          advance_cursor(32);
          add_word(1'b0, {32'd0, m0, m1}, 7'd32, 24'd0, 1'b0);
        end else begin
          advance_cursor(16);
          add_word(1'b0, {48'd0, m0}, 7'd16, 24'd0, 1'b0);
        end
      end
      CMD_END: begin
        ovr = cursor_q > CURSOR_BITS'(track_len);
        rest = ovr ? '0 : CURSOR_BITS'(track_len) - cursor_q;
        add_word(1'b1, 64'd0, 7'd0, 24'(rest >> 1), ovr);
        if (rest[0]) add_word(1'b0, 64'd1, 7'd1, 24'd0, ovr);
        if (!ovr) cursor_q = CURSOR_BITS'(track_len);
        last_data_bit = 1'b0;
      end
    endcase
    foreach (burst[i]) begin
      word = burst[i];
      word.last = (i == burst.size() - 1);
      cells_due.push_back(word);
    end
  endfunction

  // ---------------------------------------------------------------- bus side
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HEADER_MARKER: hdr_mark = value;
      CFG_DATA_MARKER:   data_mark = value;
      CFG_GAP1_PAIRS:    gap1_len = value[15:0];
      CFG_GAP3_PAIRS:    gap3_len = value[15:0];
      CFG_GAP4_PAIRS:    gap4_len = value[15:0];
      CFG_TRACK_CELLS:   track_len = value[23:0];
      default: ;
    endcase
  endtask

  task automatic set_track_regs(input logic [63:0] hm, input logic [63:0] dm,
                                input logic [15:0] g1, input logic [15:0] g3,
                                input logic [15:0] g4, input logic [23:0] tl);
    write_reg(CFG_HEADER_MARKER, hm);
    write_reg(CFG_DATA_MARKER, dm);
    write_reg(CFG_GAP1_PAIRS, 64'(g1));
    write_reg(CFG_GAP3_PAIRS, 64'(g3));
    write_reg(CFG_GAP4_PAIRS, 64'(g4));
    write_reg(CFG_TRACK_CELLS, 64'(tl));
  endtask

  task automatic send_word(input track_cmd_t c);
    int gap;
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c.dbyte, c.sec, c.side, c.trk};
    s_axis_tuser <= c.cmd;
    s_axis_tlast <= c.last;
    do @(posedge clk_i); while (!s_axis_tready);
    format_command(c);
    items_sent++;
    cmd_seen[c.cmd]++;
  endtask

  // drop valid, then let every predicted word come out
  task automatic wait_drained(input int settle);
    int waited;
    waited = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (cells_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (cells_due.size() != 0) begin
      $display("%0t ns: %0d predicted words never arrived", $time, cells_due.size());
      err_count += cells_due.size();
      cells_due.delete();
    end
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic track_cmd_t fixed_cmd(cmd_e kind, logic [6:0] trk, logic side,
                                           logic [7:0] sec, logic [7:0] dbyte, logic last);
    track_cmd_t c;
    c = {kind, trk, side, sec, dbyte, last};
    return c;
  endfunction

  // fields a command does not use are still random
  function automatic track_cmd_t random_cmd(cmd_e kind);
    track_cmd_t c;
    c.cmd = kind;
    c.trk = 7'($urandom);
    c.side = 1'($urandom);
    c.sec = 8'($urandom);
    c.dbyte = 8'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  task automatic send_noise();
    if ($urandom_range(0, 6) == 0) send_word(random_cmd(cmd_e'($urandom_range(0, 3))));
  endtask

  task automatic send_random_track(input int max_sectors, input int max_bytes);
    track_cmd_t c;
    int n_sec;
    int n_bytes;
    if ($urandom_range(0, 9) != 0) send_word(random_cmd(CMD_START));
    n_sec = $urandom_range(1, max_sectors);
    for (int s = 0; s < n_sec; s++) begin
      send_noise();
      send_word(random_cmd(CMD_HEADER));
      n_bytes = $urandom_range(1, max_bytes);
      for (int b = 0; b < n_bytes; b++) begin
        c = random_cmd(CMD_DATA);
        // mostly a clean payload: checksum flag usually on the final byte, rarely on an earlier one
        if (b == n_bytes - 1) c.last = ($urandom_range(0, 9) != 0);
        else c.last = ($urandom_range(0, 19) == 0);
        send_word(c);
      end
    end
    send_noise();
    if ($urandom_range(0, 9) != 0) send_word(random_cmd(CMD_END));
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word = {m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[70:64],
                   m_axis_tdata[94:71], m_axis_tdata[95], m_axis_tlast};
      words_checked++;
      if (seen_word.ovr) overrun_words++;
      if (cells_due.size() == 0) begin
        if (err_count < MaxReports)
          $display("%0t ns: word with nothing predicted, kind %0d cells %h count %0d pairs %0d",
                   $time, seen_word.kind, seen_word.cells, seen_word.count, seen_word.pairs);
        err_count++;
      end else begin
        due_word = cells_due.pop_front();
        if (seen_word.kind !== due_word.kind || seen_word.cells !== due_word.cells ||
            seen_word.count !== due_word.count || seen_word.pairs !== due_word.pairs ||
            seen_word.ovr !== due_word.ovr || seen_word.last !== due_word.last) begin
          if (err_count < MaxReports) begin
            $display("%0t ns: mismatch, want kind %0d cells %h count %0d pairs %0d ovr %0d last %0d",
                     $time, due_word.kind, due_word.cells, due_word.count, due_word.pairs,
                     due_word.ovr, due_word.last);
            $display("              got  kind %0d cells %h count %0d pairs %0d ovr %0d last %0d",
                     seen_word.kind, seen_word.cells, seen_word.count, seen_word.pairs,
                     seen_word.ovr, seen_word.last);
          end
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // all registers still zero: empty gaps, zero markers, track length zero
  task automatic test_register_defaults();
    send_word(fixed_cmd(CMD_START, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_HEADER, 7'd5, 1'b1, 8'd9, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd0, 1'b0, 8'd0, 8'h5A, 1'b1));
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    wait_drained(8);
  endtask

  // one clean track with field extremes, a second sector and an odd tail
  task automatic test_track_fields();
    set_track_regs(64'hA5A5_0F0F_FFFF_0001, 64'h8000_0000_0000_0001, 16'd3, 16'd2, 16'd5,
                   24'd2001);
    send_word(fixed_cmd(CMD_START, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_HEADER, 7'd127, 1'b1, 8'd255, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd0, 1'b0, 8'd0, 8'h00, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd0, 1'b0, 8'd0, 8'hFF, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd0, 1'b0, 8'd0, 8'h01, 1'b1));
    send_word(fixed_cmd(CMD_HEADER, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd127, 1'b1, 8'd255, 8'hFF, 1'b1));
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    wait_drained(8);
  endtask

  // commands outside the usual order, overrun and an exact fit
  task automatic test_out_of_order();
    write_reg(CFG_TRACK_CELLS, 64'd2000);
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    wait_drained(8);
    write_reg(CFG_TRACK_CELLS, 64'd4000);
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd0, 1'b0, 8'd0, 8'h3C, 1'b0));
    send_word(fixed_cmd(CMD_HEADER, 7'd64, 1'b0, 8'd128, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd0, 1'b0, 8'd0, 8'hC3, 1'b1));
    send_word(fixed_cmd(CMD_START, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_HEADER, 7'd1, 1'b1, 8'd1, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    wait_drained(8);
  endtask

  // widest gaps drive the cursor past its top; it must stick there, not wrap
  task automatic test_cursor_saturation();
    set_track_regs('1, 64'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_word(random_cmd(CMD_START));
    repeat (132) send_word(random_cmd(CMD_HEADER));
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_word(fixed_cmd(CMD_DATA, 7'd0, 1'b0, 8'd0, 8'h77, 1'b1));
    send_word(fixed_cmd(CMD_END, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0));
    wait_drained(8);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    track_cmd_t c;
    set_track_regs(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'd4, 16'd7, 16'd2,
                   24'd5000);
    tx_idle_on = 1'b0;
    rx_hold = 300;
    send_word(random_cmd(CMD_START));
    send_word(random_cmd(CMD_HEADER));
    for (int i = 0; i < 30; i++) begin
      c = random_cmd(CMD_DATA);
      c.last = (i == 29);
      send_word(c);
    end
    send_word(random_cmd(CMD_HEADER));
    send_word(random_cmd(CMD_END));
    tx_idle_on = 1'b1;
    wait_drained(8);
  endtask

  task automatic test_random_tracks();
    int goal;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_track_regs('1, 64'd0, 16'd0, 16'd0, 16'd0, 24'd0);
        1: begin
          set_track_regs({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom_range(0, 20)),
                         16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                         24'($urandom_range(0, 3000)));
          write_reg(SpareIndex, {$urandom, $urandom});
        end
        2: set_track_regs({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 24'hFFFFFF);
        default: set_track_regs({$urandom, $urandom}, {$urandom, $urandom},
                                16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 40)), 24'($urandom_range(0, 3000)));
      endcase
      // last phase runs at full rate on both sides
      tx_idle_on = (phase != 3);
      rx_idle_on = (phase != 3);
      goal = items_sent + 20;
      while (items_sent < goal) send_random_track(4, 6);
      wait_drained(8);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    hdr_mark = '0;
    data_mark = '0;
    gap1_len = '0;
    gap3_len = '0;
    gap4_len = '0;
    track_len = '0;
    cursor_q = '0;
    last_data_bit = 1'b0;
    first_sector_q = 1'b1;
    pay_sum = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_defaults();
    test_track_fields();
    test_out_of_order();
    test_cursor_saturation();
    test_backpressure();
    test_random_tracks();
    wait_drained(8);

    $display("run covered %0d commands (start %0d, header %0d, data %0d, end %0d)",
             items_sent, cmd_seen[CMD_START], cmd_seen[CMD_HEADER], cmd_seen[CMD_DATA],
             cmd_seen[CMD_END]);
    $display("%0d result words checked, %0d flagged overrun, %0d mismatches",
             words_checked, overrun_words, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words still predicted", cells_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
